// File: sv/ccd_pkg.sv
// ----------------------------------------------------------------------------
// ccd_pkg
// Shared types and codes of the complement pair command deframer.
// ----------------------------------------------------------------------------
package ccd_pkg;

	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 32;
	localparam int unsigned ByteW = 8;
	localparam int unsigned ActW = 3;
	localparam int unsigned TickW = 32;
	localparam int unsigned FrameCntW = 2;

	// Register indexes of the configuration port
	localparam logic [CfgIdxW-1:0] REG_START_CODE = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_END_CODE = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_SKIP_CODE = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_VOLUP_CODE = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_VOLDOWN_CODE = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_SKIP_HOLDOFF = 3'd5;

	// Register reset values
	localparam logic [ByteW-1:0] START_CODE_RST = 8'd1;
	localparam logic [ByteW-1:0] END_CODE_RST = 8'd2;
	localparam logic [ByteW-1:0] SKIP_CODE_RST = 8'd3;
	localparam logic [ByteW-1:0] VOLUP_CODE_RST = 8'd4;
	localparam logic [ByteW-1:0] VOLDOWN_CODE_RST = 8'd5;
	localparam logic [TickW-1:0] SKIP_HOLDOFF_RST = 32'd500000;

	// Request types
	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// Action codes
	localparam logic [ActW-1:0] ACT_SKIP_FIRED = 3'd0;
	localparam logic [ActW-1:0] ACT_SKIP_SUPPRESSED = 3'd1;
	localparam logic [ActW-1:0] ACT_VOLUME_UP = 3'd2;
	localparam logic [ActW-1:0] ACT_VOLUME_DOWN = 3'd3;
	localparam logic [ActW-1:0] ACT_OTHER = 3'd4;

	// Frame fill levels
	localparam logic [FrameCntW-1:0] FRAME_EMPTY = 2'd0;
	localparam logic [FrameCntW-1:0] FRAME_ONE = 2'd1;

	typedef struct packed {
		logic [ByteW-1:0] start_code;
		logic [ByteW-1:0] end_code;
		logic [ByteW-1:0] skip_code;
		logic [ByteW-1:0] volup_code;
		logic [ByteW-1:0] voldown_code;
		logic [TickW-1:0] skip_holdoff;
	} ccd_cfg_t;

	typedef struct packed {
		logic valid;
		logic [ActW-1:0] action;
		logic [ByteW-1:0] command_byte;
	} ccd_result_t;

endpackage

// File: sv/ccd_cfg_regs.sv
// ----------------------------------------------------------------------------
// ccd_cfg_regs
// Configuration register file: frame codes, command codes and skip holdoff.
// ----------------------------------------------------------------------------
module ccd_cfg_regs
	import ccd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	output ccd_cfg_t            cfg
);

	ccd_cfg_t cfg_q;

	// Write the addressed register; drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_code <= START_CODE_RST;
			cfg_q.end_code <= END_CODE_RST;
			cfg_q.skip_code <= SKIP_CODE_RST;
			cfg_q.volup_code <= VOLUP_CODE_RST;
			cfg_q.voldown_code <= VOLDOWN_CODE_RST;
			cfg_q.skip_holdoff <= SKIP_HOLDOFF_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_START_CODE: cfg_q.start_code <= cfg_data[ByteW-1:0];
				REG_END_CODE: cfg_q.end_code <= cfg_data[ByteW-1:0];
				REG_SKIP_CODE: cfg_q.skip_code <= cfg_data[ByteW-1:0];
				REG_VOLUP_CODE: cfg_q.volup_code <= cfg_data[ByteW-1:0];
				REG_VOLDOWN_CODE: cfg_q.voldown_code <= cfg_data[ByteW-1:0];
				REG_SKIP_HOLDOFF: cfg_q.skip_holdoff <= cfg_data[TickW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: sv/ccd_deframe.sv
// ----------------------------------------------------------------------------
// ccd_deframe
// Input register, complement pairing, frame assembly and skip holdoff timer.
// ----------------------------------------------------------------------------
module ccd_deframe
	import ccd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             req_type,
	input  logic [ByteW-1:0] rx_byte,
	input  ccd_cfg_t         cfg,
	input  logic             out_free,
	output ccd_result_t      result
);

	logic                 valid_s1;
	logic                 req_type_s1;
	logic [ByteW-1:0]     rx_byte_s1;

	logic                 pending_valid_q;
	logic [ByteW-1:0]     pending_byte_q;
	logic [FrameCntW-1:0] frame_count_q;
	logic [ByteW-1:0]     frame_first_q;
	logic [ByteW-1:0]     frame_second_q;
	logic [TickW-1:0]     ticks_q;

	logic                 pending_valid_d;
	logic [ByteW-1:0]     pending_byte_d;
	logic [FrameCntW-1:0] frame_count_d;
	logic [ByteW-1:0]     frame_first_d;
	logic [ByteW-1:0]     frame_second_d;
	logic [TickW-1:0]     ticks_d;
	ccd_result_t          res_d;

	logic                 advance;
	logic                 accept;

	// Work out the next state and the result of the request in the input register
	always_comb begin
		pending_valid_d = pending_valid_q;
		pending_byte_d = pending_byte_q;
		frame_count_d = frame_count_q;
		frame_first_d = frame_first_q;
		frame_second_d = frame_second_q;
		ticks_d = ticks_q;
		res_d.valid = 1'b0;
		res_d.action = ACT_OTHER;
		res_d.command_byte = frame_second_q;

		if (req_type_s1 == REQ_TICK) begin
			// Advance the holdoff timer, saturating
			if (ticks_q != {TickW{1'b1}}) begin
				ticks_d = ticks_q + 1'b1;
			end
		end else if (!pending_valid_q) begin
			pending_byte_d = rx_byte_s1;
			pending_valid_d = 1'b1;
		end else if (rx_byte_s1 == ~pending_byte_q) begin
			// Pair matched: take the pending byte into the frame
			pending_valid_d = 1'b0;
			if (frame_count_q == FRAME_EMPTY) begin
				if (pending_byte_q == cfg.start_code) begin
					frame_first_d = pending_byte_q;
					frame_count_d = FRAME_ONE;
				end
			end else if (frame_first_q != cfg.start_code) begin
				frame_count_d = FRAME_EMPTY;
			end else if (frame_count_q == FRAME_ONE) begin
				frame_second_d = pending_byte_q;
				frame_count_d = frame_count_q + 1'b1;
			end else begin
				frame_count_d = FRAME_EMPTY;
				if (pending_byte_q == cfg.end_code) begin
					res_d.valid = 1'b1;
					if (frame_second_q == cfg.skip_code) begin
						res_d.action = (ticks_q > cfg.skip_holdoff) ?
							ACT_SKIP_FIRED : ACT_SKIP_SUPPRESSED;
						ticks_d = '0;
					end else if (frame_second_q == cfg.volup_code) begin
						res_d.action = ACT_VOLUME_UP;
					end else if (frame_second_q == cfg.voldown_code) begin
						res_d.action = ACT_VOLUME_DOWN;
					end
				end
			end
		end else begin
			// Mismatched pair: drop the frame, new byte becomes pending
			frame_count_d = FRAME_EMPTY;
			pending_byte_d = rx_byte_s1;
		end
	end

	// Hold the request only when it has a result and the output is busy
	assign advance = valid_s1 && (!res_d.valid || out_free);
	assign in_stall = valid_s1 && !advance;
	assign accept = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_s1 <= req_type;
			rx_byte_s1 <= rx_byte;
		end
	end

	// Commit the deframer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_valid_q <= 1'b0;
			pending_byte_q <= '0;
			frame_count_q <= FRAME_EMPTY;
			frame_first_q <= '0;
			frame_second_q <= '0;
			ticks_q <= '0;
		end else if (advance) begin
			pending_valid_q <= pending_valid_d;
			pending_byte_q <= pending_byte_d;
			frame_count_q <= frame_count_d;
			frame_first_q <= frame_first_d;
			frame_second_q <= frame_second_d;
			ticks_q <= ticks_d;
		end
	end

	assign result.valid = advance && res_d.valid;
	assign result.action = res_d.action;
	assign result.command_byte = res_d.command_byte;

endmodule

// File: sv/ccd_out_reg.sv
// ----------------------------------------------------------------------------
// ccd_out_reg
// Result register toward the output channel.
// ----------------------------------------------------------------------------
module ccd_out_reg
	import ccd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  ccd_result_t      result,
	output logic             out_free,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [ActW-1:0]  action,
	output logic [ByteW-1:0] command_byte
);

	logic             valid_q;
	logic [ActW-1:0]  action_q;
	logic [ByteW-1:0] cmd_q;

	// Free when empty or when the held result leaves this cycle
	assign out_free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (result.valid) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result.valid) begin
			action_q <= result.action;
			cmd_q <= result.command_byte;
		end
	end

	assign out_valid = valid_q;
	assign action = action_q;
	assign command_byte = cmd_q;

endmodule

// File: sv/complement_pair_command_deframer.sv
// ----------------------------------------------------------------------------
// complement_pair_command_deframer
// Pairs each serial byte with its complement, assembles start/command/end
// frames and reports skip, volume up, volume down or other commands.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------
//  in       | in_valid / in_stall   | req_type, rx_byte
//  out      | out_valid / out_stall | action, command_byte
//  cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One request per clock while the input is not stalled; a result passes from the
// input register into the result register and from there to the output.
// The input register holds a request only while it has a result and the
// result register is stalled; requests without a result keep flowing.
// Reset clears the pairing, frame and tick state and loads register defaults.
// Configuration writes are always taken.
// ----------------------------------------------------------------------------
module complement_pair_command_deframer
	import ccd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                req_type,
	input  logic [ByteW-1:0]    rx_byte,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [ActW-1:0]     action,
	output logic [ByteW-1:0]    command_byte,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	ccd_cfg_t    cfg;
	ccd_result_t result;
	logic        out_free;

	assign cfg_ready = 1'b1;

	ccd_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ccd_deframe u_deframe (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_type (req_type),
		.rx_byte  (rx_byte),
		.cfg      (cfg),
		.out_free (out_free),
		.result   (result)
	);

	ccd_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.result       (result),
		.out_free     (out_free),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.action       (action),
		.command_byte (command_byte)
	);

endmodule

// File: sv/ccd_checker.sv
// ----------------------------------------------------------------------------
// ccd_checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module ccd_checker
	import ccd_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic [ActW-1:0]     action,
	input logic [ByteW-1:0]    command_byte,
	input logic                cfg_valid,
	input logic                cfg_ready
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(action) && $stable(command_byte))
		else $error("stalled result changed");

	// Input backpressure only comes from a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// A fresh result traces back to a request taken into the input register
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without a request");

	// Configuration writes are never refused
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind complement_pair_command_deframer ccd_checker u_ccd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.action       (action),
	.command_byte (command_byte),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready)
);

// File: tb/complement_pair_command_deframer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complement_pair_command_deframer_tb
// Drives serial byte and tick requests into the deframer and checks each
// command report against a cycle-free model of the pairing, framing and
// skip hold-off logic. Directed cases come first, then random traffic under
// changing sender and receiver idle patterns, and finally a long output hold.
// ----------------------------------------------------------------------------
module complement_pair_command_deframer_tb;
	import ccd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DRAIN_LIMIT = 5000;
	localparam int unsigned PIPE_SETTLE = 6;
	localparam int unsigned LONG_HOLD = 80;
	localparam logic [FrameCntW-1:0] FRAME_TWO = 2'd2;

	typedef struct packed {
		logic [ActW-1:0] action;
		logic [ByteW-1:0] command_byte;
	} cmd_report_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic req_type;
	logic [ByteW-1:0] rx_byte;
	logic out_valid;
	logic out_stall;
	logic [ActW-1:0] action;
	logic [ByteW-1:0] command_byte;
	logic cfg_valid;
	logic cfg_ready;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	// Model copy of the registers and the deframer state
	ccd_cfg_t cfg_m;
	logic pend_valid_m;
	logic [ByteW-1:0] pend_byte_m;
	logic [FrameCntW-1:0] frame_fill_m;
	logic [ByteW-1:0] frame_head_m;
	logic [ByteW-1:0] frame_cmd_m;
	logic [TickW-1:0] ticks_m;

	cmd_report_t expected_reports[$];

	int unsigned sender_idle_pct = 0;
	int unsigned receiver_idle_pct = 0;
	int unsigned hold_trigger = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	int unsigned cycle_count = 0;
	int unsigned requests_sent = 0;
	int unsigned reports_checked = 0;
	int unsigned skips_fired = 0;
	int unsigned settings_loaded = 0;
	int unsigned error_count = 0;

	complement_pair_command_deframer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.action       (action),
		.command_byte (command_byte),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Stall the output at random, or hold it for a long stretch on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_trigger != hold_seen) begin
				hold_seen = hold_trigger;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left = hold_left - 1;
			end else begin
				out_stall <= ($urandom_range(99) < receiver_idle_pct);
			end
		end
	end

	// Abort a hung run
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles", cycle_count);
		$display("Some tests failed");
		$finish;
	end

	// Compare each taken report with the oldest expected one
	always @(posedge clk) begin : check_reports
		cmd_report_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_reports.size() == 0) begin
				$error("unexpected report: action %0d, command_byte 0x%02h",
					action, command_byte);
				error_count++;
			end else begin
				want = expected_reports.pop_front();
				if (action !== want.action) begin
					$error("action: expected %0d, got %0d", want.action, action);
					error_count++;
				end
				if (command_byte !== want.command_byte) begin
					$error("command_byte: expected 0x%02h, got 0x%02h",
						want.command_byte, command_byte);
					error_count++;
				end
				reports_checked++;
			end
		end
	end

	task automatic model_reset();
		cfg_m = '{START_CODE_RST, END_CODE_RST, SKIP_CODE_RST, VOLUP_CODE_RST,
			VOLDOWN_CODE_RST, SKIP_HOLDOFF_RST};
		pend_valid_m = 1'b0;
		pend_byte_m = '0;
		frame_fill_m = FRAME_EMPTY;
		frame_head_m = '0;
		frame_cmd_m = '0;
		ticks_m = '0;
	endtask

	// Advance the frame with one byte that passed the complement check
	task automatic model_frame_byte(input logic [ByteW-1:0] b);
		cmd_report_t rep;
		if (frame_fill_m == FRAME_EMPTY) begin
			if (b == cfg_m.start_code) begin
				frame_head_m = b;
				frame_fill_m = FRAME_ONE;
			end
		end else if (frame_head_m != cfg_m.start_code) begin
			frame_fill_m = FRAME_EMPTY;
		end else if (frame_fill_m == FRAME_ONE) begin
			frame_cmd_m = b;
			frame_fill_m = FRAME_TWO;
		end else begin
			frame_fill_m = FRAME_EMPTY;
			if (b == cfg_m.end_code) begin
				if (frame_cmd_m == cfg_m.skip_code) begin
					rep.action = (ticks_m > cfg_m.skip_holdoff) ? ACT_SKIP_FIRED
						: ACT_SKIP_SUPPRESSED;
					ticks_m = '0;
				end else if (frame_cmd_m == cfg_m.volup_code) begin
					rep.action = ACT_VOLUME_UP;
				end else if (frame_cmd_m == cfg_m.voldown_code) begin
					rep.action = ACT_VOLUME_DOWN;
				end else begin
					rep.action = ACT_OTHER;
				end
				rep.command_byte = frame_cmd_m;
				if (rep.action == ACT_SKIP_FIRED)
					skips_fired++;
				expected_reports = {expected_reports, rep};
			end
		end
	endtask

	// Apply one accepted request to the model
	task automatic model_request(input logic t, input logic [ByteW-1:0] b);
		if (t == REQ_TICK) begin
			if (ticks_m != '1)
				ticks_m = ticks_m + 1'b1;
		end else if (!pend_valid_m) begin
			pend_byte_m = b;
			pend_valid_m = 1'b1;
		end else if (b == ~pend_byte_m) begin
			pend_valid_m = 1'b0;
			model_frame_byte(pend_byte_m);
		end else begin
			frame_fill_m = FRAME_EMPTY;
			pend_byte_m = b;
		end
	endtask

	// Offer one request, idling first at random, and hold it until taken
	task automatic send_request(input logic t, input logic [ByteW-1:0] b);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= t;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		requests_sent++;
		model_request(t, b);
	endtask

	// Send a byte and its complement, with stray ticks before and between them if asked
	task automatic send_pair(input logic [ByteW-1:0] b, input bit strays);
		if (strays && $urandom_range(9) == 0)
			send_request(REQ_TICK, ByteW'($urandom));
		send_request(REQ_BYTE, b);
		if (strays && $urandom_range(9) == 0)
			send_request(REQ_TICK, ByteW'($urandom));
		send_request(REQ_BYTE, ~b);
	endtask

	task automatic send_frame(input logic [ByteW-1:0] head, cmd, tail);
		send_pair(head, 1'b0);
		send_pair(cmd, 1'b0);
		send_pair(tail, 1'b0);
	endtask

	task automatic send_ticks(input int unsigned n);
		repeat (n) send_request(REQ_TICK, ByteW'($urandom));
	endtask

	// Drop valid, wait for every report to drain, then let the pipe settle
	task automatic settle_idle();
		int unsigned waited = 0;
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_reports.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (expected_reports.size() != 0) begin
			$error("%0d command reports never arrived", expected_reports.size());
			error_count++;
			expected_reports.delete();
		end
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	task automatic write_register(input logic [CfgIdxW-1:0] idx,
		input logic [CfgDataW-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_START_CODE: cfg_m.start_code = data[ByteW-1:0];
			REG_END_CODE: cfg_m.end_code = data[ByteW-1:0];
			REG_SKIP_CODE: cfg_m.skip_code = data[ByteW-1:0];
			REG_VOLUP_CODE: cfg_m.volup_code = data[ByteW-1:0];
			REG_VOLDOWN_CODE: cfg_m.voldown_code = data[ByteW-1:0];
			REG_SKIP_HOLDOFF: cfg_m.skip_holdoff = data[TickW-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_settings(input ccd_cfg_t s);
		settle_idle();
		write_register(REG_START_CODE, CfgDataW'(s.start_code));
		write_register(REG_END_CODE, CfgDataW'(s.end_code));
		write_register(REG_SKIP_CODE, CfgDataW'(s.skip_code));
		write_register(REG_VOLUP_CODE, CfgDataW'(s.volup_code));
		write_register(REG_VOLDOWN_CODE, CfgDataW'(s.voldown_code));
		write_register(REG_SKIP_HOLDOFF, CfgDataW'(s.skip_holdoff));
		settings_loaded++;
	endtask

	// Random codes, with volume up sometimes colliding with skip and volume down with volume up
	function automatic ccd_cfg_t random_settings(input logic [TickW-1:0] holdoff);
		ccd_cfg_t s;
		s.start_code = ByteW'($urandom);
		s.end_code = ByteW'($urandom);
		s.skip_code = ByteW'($urandom);
		s.volup_code = ($urandom_range(5) == 0) ? s.skip_code : ByteW'($urandom);
		s.voldown_code = ($urandom_range(5) == 0) ? s.volup_code : ByteW'($urandom);
		s.skip_holdoff = holdoff;
		return s;
	endfunction

	// Mostly good frames; now and then a wrong start or end byte
	task automatic send_random_frame();
		logic [ByteW-1:0] head;
		logic [ByteW-1:0] cmd;
		logic [ByteW-1:0] tail;
		head = ($urandom_range(9) != 0) ? cfg_m.start_code : ByteW'($urandom);
		case ($urandom_range(4))
			0: cmd = cfg_m.skip_code;
			1: cmd = cfg_m.volup_code;
			2: cmd = cfg_m.voldown_code;
			default: cmd = ByteW'($urandom);
		endcase
		tail = ($urandom_range(9) != 0) ? cfg_m.end_code : ByteW'($urandom);
		send_pair(head, 1'b1);
		send_pair(cmd, 1'b1);
		send_pair(tail, 1'b1);
	endtask

	// Default codes straight out of reset
	task automatic test_reset_defaults();
		sender_idle_pct = 20;
		receiver_idle_pct = 20;
		send_frame(START_CODE_RST, SKIP_CODE_RST, END_CODE_RST);
		send_frame(START_CODE_RST, VOLUP_CODE_RST, END_CODE_RST);
		send_frame(START_CODE_RST, VOLDOWN_CODE_RST, END_CODE_RST);
		send_frame(START_CODE_RST, 8'hFF, END_CODE_RST);
	endtask

	// Code collisions, skip hold-off at both extremes, restart on skip press
	task automatic test_codes_and_holdoff();
		load_settings('{8'h00, 8'hFF, 8'hA5, 8'hA5, 8'hA5, 32'd0});
		send_frame(8'h00, 8'hA5, 8'hFF);
		send_ticks(1);
		send_frame(8'h00, 8'hA5, 8'hFF);
		send_frame(8'h00, 8'hA5, 8'hFF);
		settle_idle();
		write_register(REG_SKIP_CODE, CfgDataW'(8'h5A));
		write_register(REG_SKIP_HOLDOFF, 32'hFFFF_FFFF);
		send_frame(8'h00, 8'hA5, 8'hFF);
		send_ticks(3);
		send_frame(8'h00, 8'h5A, 8'hFF);
	endtask

	// Broken pairs, stray ticks, bad start and end bytes, start code swap
	task automatic test_broken_pairs();
		load_settings('{8'h3C, 8'hC3, 8'h11, 8'h22, 8'h33, 32'd2});
		send_request(REQ_BYTE, 8'h3C);
		send_request(REQ_BYTE, 8'h00);
		send_request(REQ_BYTE, 8'hFF);
		send_frame(8'h3C, 8'h22, 8'hC3);
		send_request(REQ_BYTE, 8'h3C);
		send_request(REQ_TICK, 8'h3C);
		send_request(REQ_BYTE, 8'hC3);
		send_pair(8'h44, 1'b0);
		send_pair(8'hC3, 1'b0);
		send_pair(8'h55, 1'b0);
		send_frame(8'h3C, 8'h3C, 8'h00);
		send_frame(8'h3C, 8'h11, 8'hC3);
		// swap the start code while a frame is half built
		send_pair(8'h3C, 1'b0);
		settle_idle();
		write_register(REG_START_CODE, CfgDataW'(8'h96));
		send_pair(8'h22, 1'b0);
		send_pair(8'hC3, 1'b0);
		send_frame(8'h96, 8'h33, 8'hC3);
	endtask

	task automatic test_random_traffic(input int unsigned sender_pct, receiver_pct,
		input ccd_cfg_t s, input int unsigned n);
		int unsigned stop_at;
		int unsigned pick;
		load_settings(s);
		sender_idle_pct = sender_pct;
		receiver_idle_pct = receiver_pct;
		stop_at = requests_sent + n;
		while (requests_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				send_random_frame();
			end else if (pick < 82) begin
				send_ticks($urandom_range(1, 6));
			end else if (pick < 91) begin
				send_request(REQ_BYTE, ByteW'($urandom));
			end else begin
				send_request(REQ_BYTE, ByteW'($urandom));
				send_request(REQ_BYTE, ByteW'($urandom));
			end
		end
	endtask

	// Hold the output long enough that the input stalls behind it
	task automatic test_output_backpressure();
		load_settings(random_settings(32'd3));
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		hold_trigger++;
		repeat (20)
			send_frame(cfg_m.start_code, ByteW'($urandom), cfg_m.end_code);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_BYTE;
		rx_byte = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_START_CODE;
		cfg_data = '0;
		model_reset();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_codes_and_holdoff();
		test_broken_pairs();
		test_random_traffic(33, 79, random_settings(32'd4), 560);
		test_random_traffic(79, 33, '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'h7F, 32'd0}, 560);
		test_random_traffic(0, 0, random_settings(32'd9), 560);
		test_output_backpressure();
		settle_idle();

		$display("Sent %0d requests under %0d register settings; checked %0d reports",
			requests_sent, settings_loaded, reports_checked);
		$display("(%0d skips fired), incl. broken pairs, bad frames and a %0d-cycle hold.",
			skips_fired, LONG_HOLD);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: complement_pair_command_deframer.f
sv/ccd_pkg.sv
sv/ccd_cfg_regs.sv
sv/ccd_deframe.sv
sv/ccd_out_reg.sv
sv/complement_pair_command_deframer.sv
sv/ccd_checker.sv
tb/complement_pair_command_deframer_tb.sv
